FILE: rtl/core/qse_pkg.sv
// qse_pkg: shared types, constants and controller commands for the quicksort engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package qse_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int VALUE_W         = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_item;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_result;
        logic                      overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_POP,
        S_POP_WAIT,
        S_PIVOT,
        S_RD_HI,
        S_CMP_HI,
        S_RD_LO,
        S_CMP_LO,
        S_PLACE,
        S_PUSH_R,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    // Datapath commands, one bit per micro-operation.
    typedef struct packed {
        logic store_in;    // store the input value or flag overflow
        logic start;       // clear the emit index, push the full range if count >= 2
        logic pop;         // pop a range, read the stack top
        logic load_range;  // latch range bounds, read the pivot element
        logic latch_pivot; // latch the pivot from store read data
        logic rd_hi;       // read store[hi]
        logic dec_hi;      // hi <= hi - 1
        logic wr_lo;       // store[lo] <= read data
        logic rd_lo;       // read store[lo]
        logic inc_lo;      // lo <= lo + 1
        logic wr_hi;       // store[hi] <= read data
        logic place;       // store[lo] <= pivot, push left sub-range
        logic push_r;      // push right sub-range
        logic emit_rd;     // read store[k]
        logic emit_load;   // load the output register, advance k
        logic clear_set;   // clear count and overflow flag
    } t_dp_cmd;

    typedef struct packed {
        logic count_lt2;
        logic sp_zero;
        logic lo_lt_hi;
        logic data_ge_piv;
        logic data_le_piv;
        logic out_free;
        logic k_last;
    } t_dp_stat;

endpackage

`default_nettype wire

FILE: rtl/core/qse_ctrl.sv
// qse_ctrl: sequencer for load, quicksort partitioning and emit.
// Depends on qse_pkg; drives the datapath qse_dp through t_dp_cmd.
`default_nettype none

module qse_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_last,
    input  wire qse_pkg::t_dp_stat i_stat,
    output logic                  o_in_ready,
    output qse_pkg::t_dp_cmd      o_cmd
);
    import qse_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_in = 1'b1;
                    if (i_in_last) n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_stat.count_lt2 ? S_EMIT_RD : S_POP;
            end
            S_POP: begin
                if (i_stat.sp_zero) begin
                    n_state = S_EMIT_RD;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                o_cmd.load_range = 1'b1;
                n_state          = S_PIVOT;
            end
            S_PIVOT: begin
                o_cmd.latch_pivot = 1'b1;
                n_state           = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.rd_hi = 1'b1;
                n_state     = S_CMP_HI;
            end
            S_CMP_HI: begin
                if (i_stat.lo_lt_hi && i_stat.data_ge_piv) begin
                    o_cmd.dec_hi = 1'b1;
                    n_state      = S_RD_HI;
                end else begin
                    o_cmd.wr_lo = 1'b1;
                    n_state     = S_RD_LO;
                end
            end
            S_RD_LO: begin
                o_cmd.rd_lo = 1'b1;
                n_state     = S_CMP_LO;
            end
            S_CMP_LO: begin
                if (i_stat.lo_lt_hi && i_stat.data_le_piv) begin
                    o_cmd.inc_lo = 1'b1;
                    n_state      = S_RD_LO;
                end else begin
                    o_cmd.wr_hi = 1'b1;
                    n_state     = i_stat.lo_lt_hi ? S_RD_HI : S_PLACE;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_PUSH_R;
            end
            S_PUSH_R: begin
                o_cmd.push_r = 1'b1;
                n_state      = S_POP;
            end
            S_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                // hold read data until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (i_stat.k_last) begin
                        o_cmd.clear_set = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/qse_dp.sv
// qse_dp: element store, range stack, index registers and output register.
// Depends on qse_pkg; commanded by qse_ctrl.
`default_nettype none

module qse_dp #(
    parameter int MAX_ENTRIES = qse_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire qse_pkg::t_in_item i_in_data,
    input  wire logic              i_out_ready,
    input  wire qse_pkg::t_dp_cmd  i_cmd,
    output qse_pkg::t_dp_stat      o_stat,
    output logic                   o_out_valid,
    output qse_pkg::t_out_item     o_out_data
);
    import qse_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    logic [VALUE_W-1:0] r_store [MAX_ENTRIES];
    logic [2*IDX_W-1:0] r_stack [MAX_ENTRIES];

    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_sp;
    logic [IDX_W-1:0]   r_lo, r_hi, r_olo, r_ohi, r_k;
    logic [VALUE_W-1:0] r_pivot;
    logic [VALUE_W-1:0] r_rdata;
    logic [2*IDX_W-1:0] r_srdata;
    logic               r_out_valid;
    t_out_item          r_out;

    logic               st_we, st_re, sk_we;
    logic [IDX_W-1:0]   st_waddr, st_raddr, sk_waddr;
    logic [VALUE_W-1:0] st_wdata;
    logic [2*IDX_W-1:0] sk_wdata;
    logic               full, left_ok, right_ok, push_en;
    logic [CNT_W-1:0]   lo_ext;

    assign full    = (r_count == CNT_MAX);
    assign lo_ext  = CNT_W'(r_lo);
    assign left_ok = ((CNT_W'(r_olo) + CNT_W'(2)) <= lo_ext);
    assign right_ok = ((lo_ext + CNT_W'(1)) < CNT_W'(r_ohi));

    // Store write port
    always_comb begin
        st_we    = 1'b0;
        st_waddr = r_lo;
        st_wdata = r_rdata;
        if (i_cmd.store_in && !full) begin
            st_we    = 1'b1;
            st_waddr = r_count[IDX_W-1:0];
            st_wdata = i_in_data.value;
        end else if (i_cmd.wr_lo) begin
            st_we = 1'b1;
        end else if (i_cmd.wr_hi) begin
            st_we    = 1'b1;
            st_waddr = r_hi;
        end else if (i_cmd.place) begin
            st_we    = 1'b1;
            st_wdata = r_pivot;
        end
    end

    // Store read port
    always_comb begin
        st_re    = i_cmd.load_range | i_cmd.rd_hi | i_cmd.rd_lo | i_cmd.emit_rd;
        st_raddr = r_lo;
        if (i_cmd.load_range) st_raddr = r_srdata[2*IDX_W-1:IDX_W];
        else if (i_cmd.rd_hi) st_raddr = r_hi;
        else if (i_cmd.emit_rd) st_raddr = r_k;
    end

    // Stack write port
    always_comb begin
        sk_we    = 1'b0;
        sk_waddr = r_sp[IDX_W-1:0];
        sk_wdata = {r_olo, r_lo - IDX_W'(1)};
        if (i_cmd.start && !o_stat.count_lt2) begin
            sk_we    = 1'b1;
            sk_wdata = {{IDX_W{1'b0}}, IDX_W'(r_count - CNT_W'(1))};
        end else if (i_cmd.place && left_ok) begin
            sk_we = 1'b1;
        end else if (i_cmd.push_r && right_ok) begin
            sk_we    = 1'b1;
            sk_wdata = {r_lo + IDX_W'(1), r_ohi};
        end
    end
    // drop a push onto a full stack
    assign push_en = sk_we && (r_sp != CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (st_we) r_store[st_waddr] <= st_wdata;
        if (st_re) r_rdata <= r_store[st_raddr];
        if (push_en) r_stack[sk_waddr] <= sk_wdata;
        if (i_cmd.pop) r_srdata <= r_stack[IDX_W'(r_sp - CNT_W'(1))];
    end

    // Control-state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store_in) begin
                if (full) r_ovf <= 1'b1;
                else      r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.clear_set) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end
            if (i_cmd.start) r_sp <= '0;
            if (push_en) r_sp <= r_sp + CNT_W'(1);
            else if (i_cmd.pop) r_sp <= r_sp - CNT_W'(1);
            if (i_cmd.emit_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_range) begin
            r_lo  <= r_srdata[2*IDX_W-1:IDX_W];
            r_olo <= r_srdata[2*IDX_W-1:IDX_W];
            r_hi  <= r_srdata[IDX_W-1:0];
            r_ohi <= r_srdata[IDX_W-1:0];
        end
        if (i_cmd.dec_hi) r_hi <= r_hi - IDX_W'(1);
        if (i_cmd.inc_lo) r_lo <= r_lo + IDX_W'(1);
        if (i_cmd.latch_pivot) r_pivot <= r_rdata;
        if (i_cmd.start) r_k <= '0;
        else if (i_cmd.emit_load) r_k <= r_k + IDX_W'(1);
        if (i_cmd.emit_load) begin
            r_out.sorted_value <= $signed(r_rdata);
            r_out.last_result  <= o_stat.k_last;
            r_out.overflow     <= r_ovf;
        end
    end

    // start pushes the full range at sp 0, so the pointer is cleared then bumped
    always_comb begin
        o_stat.count_lt2   = (r_count < CNT_W'(2));
        o_stat.sp_zero     = (r_sp == '0);
        o_stat.lo_lt_hi    = (r_lo < r_hi);
        o_stat.data_ge_piv = ($signed(r_rdata) >= $signed(r_pivot));
        o_stat.data_le_piv = ($signed(r_rdata) <= $signed(r_pivot));
        o_stat.out_free    = !r_out_valid || i_out_ready;
        o_stat.k_last      = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: rtl/core/quicksort_engine_core.sv
// quicksort_engine_core: top level of the quicksort engine.
// Depends on qse_pkg, qse_ctrl and qse_dp.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------------
//   input   | in        | i_in_valid/o_in_ready  | i_in_data  (t_in_item)
//   output  | out       | o_out_valid/i_out_ready| o_out_data (t_out_item)
//
// Loading takes one cycle per request; o_in_ready is high only while idle.
// After a last request the sort runs on an element store with one read and one
// write port and a range stack: each popped range passes the pop, pop-wait and
// pivot states, each element visited by a partition scan a read and a compare
// state, and each range a place and a push state to place the pivot and push.
// Emit reads each result from the store, then loads the output register once free.
// Reset is synchronous and clears the state, count, overflow flag, stack
// pointer and output valid; the store and stack need no clearing pass.
// A stalled output holds the sequencer in its load state; the next set's
// first request is taken while the final result still waits.
`default_nettype none

module quicksort_engine_core #(
    parameter int MAX_ENTRIES = qse_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire qse_pkg::t_in_item  i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output qse_pkg::t_out_item      o_out_data
);
    import qse_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer: decides each micro-operation from datapath status
    qse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_item),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    // datapath: store, stack, partition indexes, pivot and output register
    qse_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

FILE: rtl/core/qse_checker.sv
// qse_port_checker: port-level assertions for quicksort_engine_core, bound to the top.
// Depends on qse_pkg.
`default_nettype none

module qse_port_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire qse_pkg::t_in_item  i_in_data,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire qse_pkg::t_out_item o_out_data
);
    import qse_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output request dropped or changed while stalled");

    // a last request starts the sort, so the input closes next cycle
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last_item |=> !o_in_ready)
        else $error("input ready right after a last request");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a result never appears while loading is still open with no prior last
    a_ready_no_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result emitted without a sort");

endmodule

bind quicksort_engine_core qse_port_checker u_qse_checker (.*);

`default_nettype wire

FILE: verif/qse_checker.sv
// qse_checker: scoreboard for the quicksort engine, watches both request channels.
// Keeps a sorted copy of each incoming set and compares every emitted result.
// Depends on qse_pkg.
module qse_checker #(
    parameter int MAX_ENTRIES = qse_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire qse_pkg::t_in_item  i_in_data,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire qse_pkg::t_out_item i_out_data,
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_results_seen
);
    import qse_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Current set, kept in ascending order as it grows.
    logic signed [VALUE_W-1:0] held_sorted[$];
    logic                      set_dropped = 1'b0;
    t_out_item                 sorted_due[$];
    int                        fails = 0;
    int                        seen = 0;

    always @(posedge i_clk) begin : watch
        t_out_item                 want;
        logic signed [VALUE_W-1:0] incoming;
        int                        pos;
        if (!i_rst_n) begin
            held_sorted.delete();
            sorted_due.delete();
            set_dropped = 1'b0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                seen++;
                if (sorted_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("unexpected result: value %0d last %0b ovf %0b",
                                 i_out_data.sorted_value, i_out_data.last_result,
                                 i_out_data.overflow);
                end else begin
                    want = sorted_due.pop_front();
                    if (want.sorted_value !== i_out_data.sorted_value ||
                        want.last_result !== i_out_data.last_result ||
                        want.overflow !== i_out_data.overflow) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                                     want.sorted_value, want.last_result, want.overflow,
                                     i_out_data.sorted_value, i_out_data.last_result,
                                     i_out_data.overflow);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                incoming = i_in_data.value;
                // Drop values beyond capacity, but remember it for the whole set.
                if (held_sorted.size() < MAX_ENTRIES) begin
                    pos = 0;
                    while (pos < held_sorted.size() && held_sorted[pos] <= incoming)
                        pos++;
                    held_sorted.insert(pos, incoming);
                end else begin
                    set_dropped = 1'b1;
                end
                if (i_in_data.last_item) begin
                    for (int k = 0; k < held_sorted.size(); k++)
                        sorted_due.push_back('{sorted_value: held_sorted[k],
                                               last_result: (k == held_sorted.size() - 1),
                                               overflow: set_dropped});
                    held_sorted.delete();
                    set_dropped = 1'b0;
                end
            end
        end
        o_fail_count   <= fails;
        o_pending      <= sorted_due.size();
        o_results_seen <= seen;
    end

endmodule

FILE: verif/quicksort_engine_core_test.sv
// quicksort_engine_core_test: top of the quicksort engine testbench.
// Drives sets of values with random gaps and output stalls; depends on qse_pkg,
// quicksort_engine_core and qse_checker.
module quicksort_engine_core_test;
    import qse_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int MAX_ENTRIES  = MAX_ENTRIES_DEF;
    localparam int ITEM_TARGET  = 500;
    localparam int CALM_FROM    = 440;   // no idling on either side past this point
    localparam int LONG_HOLD_AT = 100;   // results seen before the long output stall
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 300;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    // How the values of one set are chosen.
    typedef enum int {
        FILL_WIDE,     // full 32-bit random
        FILL_NARROW,   // small range, many duplicates
        FILL_EDGE,     // extremes and their neighbors
        FILL_RISING,   // already ascending: worst case for a first-element pivot
        FILL_FALLING   // descending
    } t_fill_mode;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    int        fail_count;
    int        pending;
    int        results_seen;

    int        items_sent = 0;
    bit        calm = 1'b0;
    logic signed [VALUE_W-1:0] batch[$];

    quicksort_engine_core #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    qse_checker #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or never drains.
    initial begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("tb: failure");
        $finish;
    end

    // Offer one request and hold it until the block takes it, then maybe idle a burst.
    task automatic offer(input logic signed [VALUE_W-1:0] v, input logic last);
        int gap;
        in_data  <= '{value: v, last_item: last};
        in_valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        items_sent++;
        if (items_sent >= CALM_FROM)
            calm = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Send the queued values as one set; the final one carries the last marker.
    task automatic send_batch();
        for (int i = 0; i < batch.size(); i++)
            offer(batch[i], i == batch.size() - 1);
    endtask

    // Build a set of n values in the given style and send it.
    task automatic send_set(input int n, input t_fill_mode mode);
        logic signed [VALUE_W-1:0] run;
        logic signed [VALUE_W-1:0] edge_vals[6];
        edge_vals = '{VAL_MIN, VAL_MAX, '0, -1, VAL_MIN + 1, VAL_MAX - 1};
        run = $urandom;
        batch.delete();
        for (int i = 0; i < n; i++) begin
            case (mode)
                FILL_WIDE:    batch.push_back($urandom);
                FILL_NARROW:  batch.push_back($signed($urandom_range(0, 15)) - 8);
                FILL_EDGE:    batch.push_back(edge_vals[$urandom_range(0, 5)]);
                FILL_RISING: begin
                    run = run + $urandom_range(0, 1000);
                    batch.push_back(run);
                end
                default: begin
                    run = run - $urandom_range(0, 1000);
                    batch.push_back(run);
                end
            endcase
        end
        send_batch();
    endtask

    // Stop offering until every expected result has been taken.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Output side: random stall bursts, one long hold-off so the block backs up into
    // its input, and always ready once the run is calm.
    initial begin : receiver
        int  stall_left;
        int  pass_left;
        bit  long_done;
        stall_left = 0;
        pass_left  = 0;
        long_done  = 1'b0;
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!long_done && results_seen >= LONG_HOLD_AT) begin
                long_done  = 1'b1;
                stall_left = LONG_HOLD;
                pass_left  = 0;
            end else if (stall_left == 0 && pass_left == 0) begin
                if (calm)
                    pass_left = 1;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = $urandom_range(1, 7);
                else
                    pass_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready <= 1'b1;
                if (pass_left > 0)
                    pass_left--;
            end
        end
    end

    initial begin : stimulus
        int         set_no;
        int         set_len;
        int         pick;
        t_fill_mode mode;
        in_valid <= 1'b0;
        in_data  <= '0;
        i_rst_n  <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sets: a lone value, extremes with duplicates, sorted input,
        // reversed input and a set of equal values.
        batch = '{VAL_MAX};
        send_batch();
        batch = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN, VAL_MAX};
        send_batch();
        batch = '{-2, -1, 0, 1, 2};
        send_batch();
        batch = '{100, 50, 0, -50, -100};
        send_batch();
        batch = '{7, 7, 7, 7};
        send_batch();
        wait_drained();

        // Random sets, mostly short; force one exactly full set and one that
        // overflows, with the last request dropped.
        set_no = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 19);
            if (set_no == 3)
                set_len = MAX_ENTRIES;
            else if (set_no == 6)
                set_len = MAX_ENTRIES + 1 + $urandom_range(0, 5);
            else if (pick == 0)
                set_len = MAX_ENTRIES;
            else if (pick == 1)
                set_len = MAX_ENTRIES + $urandom_range(1, 6);
            else if (pick < 5)
                set_len = $urandom_range(13, 40);
            else
                set_len = $urandom_range(1, 12);
            mode = t_fill_mode'($urandom_range(0, 4));
            send_set(set_len, mode);
            if (set_no == 10)
                wait_drained();
            set_no++;
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
